// ===== rtl/mac_learning_table_aging_assert.svh =====
// ----------------------------------------------------------------------------
// MAC learning table assertion macros
// Shorthand for the concurrent checks used in the table RTL. Each macro
// expects signals named clock and reset in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_TABLE_AGING_ASSERT_SVH
`define MAC_LEARNING_TABLE_AGING_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset
`define MLTA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define MLTA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mlta_pkg.sv =====
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared types and constants: operation codes, table entry layout, result
// layout and configuration register map.
// ----------------------------------------------------------------------------
package mlta_pkg;

   // Operation codes carried in the request tuser
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int MAC_W   = 48;
   localparam int PORT_W  = 8;
   localparam int AGE_W   = 8;
   localparam int COUNT_W = 11;

   localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

   // Configuration register map (word index taken from paddr[2])
   localparam int         CSR_ADDR_W        = 3;
   localparam logic       REG_AGING_LIMIT   = 1'b0;
   localparam logic [7:0] AGING_LIMIT_RESET = 8'd30;

   // One table entry as stored in the memory
   typedef struct packed {
      logic              valid;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
      logic [AGE_W-1:0]  age;
   } entry_type;

   // One result beat
   typedef struct packed {
      logic [COUNT_W-1:0] removed_count;
      logic               table_full;
      logic [PORT_W-1:0]  found_port;
      logic               hit;
   } result_type;

endpackage

// ===== rtl/mac_learning_table_aging.sv =====
// ----------------------------------------------------------------------------
// MAC learning table with aging
// Fully associative station address table: lookup, insert and aging
// tick, with a registered result stage on the response stream.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake              | Payload
//  req_    | in  | req_tvalid/req_tready  | tdata mac+port, tuser operation
//  rsp_    | out | rsp_tvalid/rsp_tready  | tdata hit, port, full, removed
//  csr_    | in  | APB psel/penable       | aging_limit at word 0
//
//  Each request beat is handled by a scan of the entry memory's single read
//  port, one entry a cycle, and then a final step; operation code 3 goes
//  straight to the final step.
//  After reset a clearing pass writes every entry invalid; req_tready stays
//  low until it ends.
//  A result waits in the output register; the next request is accepted and
//  scanned meanwhile, and only the final step stalls on rsp_tready.
// ----------------------------------------------------------------------------
module mac_learning_table_aging #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [55:0]                     req_tdata,  // [47:0] mac_address, [55:48] port
   input  logic [1:0]                      req_tuser,  // [1:0] operation
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // [0] hit, [8:1] found_port,
                                                       // [9] table_full, [20:10] removed_count
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mlta_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int AddrW = $clog2(TABLE_ENTRIES);

   logic [7:0]           aging_limit;
   logic                 idle;
   logic                 start;
   logic                 out_free;
   logic                 done;
   mlta_pkg::result_type result;

   logic                 rd_en;
   logic [AddrW-1:0]     rd_addr;
   mlta_pkg::entry_type  rd_data;
   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr;
   mlta_pkg::entry_type  wr_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   mlta_pkg::result_type rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign start      = req_tvalid & req_tready;

   mlta_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .aging_limit (aging_limit)
   );

   mlta_entry_mem #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mlta_scan_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .aging_limit (aging_limit),
      .start       (start),
      .start_op    (req_tuser),
      .start_mac   (req_tdata[47:0]),
      .start_port  (req_tdata[55:48]),
      .idle        (idle),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // Output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

// ===== rtl/mlta_entry_mem.sv =====
// ----------------------------------------------------------------------------
// MAC table entry memory
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mlta_entry_mem #(
   parameter int TABLE_ENTRIES = 64,
   localparam int AddrW = $clog2(TABLE_ENTRIES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrW-1:0]    wr_addr,
   input  mlta_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AddrW-1:0]    rd_addr,
   output mlta_pkg::entry_type rd_data
);

   mlta_pkg::entry_type entry_mem [TABLE_ENTRIES];
   mlta_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mlta_csr_regs.sv =====
// ----------------------------------------------------------------------------
// MAC table configuration registers
// APB-style register port holding the aging limit. It never inserts wait states.
// ----------------------------------------------------------------------------
module mlta_csr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mlta_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [7:0]                      aging_limit
);

   logic [7:0] limit_ff;
   logic [7:0] limit_in;
   logic       sel_limit;
   logic       wr_beat;

   assign csr_pready = 1'b1;
   assign sel_limit  = (csr_paddr[2] == mlta_pkg::REG_AGING_LIMIT);
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write
   always_comb begin
      limit_in = limit_ff;
      if (wr_beat && sel_limit) begin
         limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mlta_pkg::AGING_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read back; unmapped words read zero
   assign csr_prdata  = sel_limit ? {24'd0, limit_ff} : 32'd0;
   assign aging_limit = limit_ff;

endmodule

// ===== rtl/mlta_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// MAC table scan sequencer
// Clears the table after reset, then runs one operation at a time: a full
// read scan of the entry memory (one entry per cycle) but for code 3, aging
// write-back for ticks, and a final entry write for lookups and inserts.
// ----------------------------------------------------------------------------
`include "mac_learning_table_aging_assert.svh"

module mlta_scan_ctrl #(
   parameter int TABLE_ENTRIES = 64,
   localparam int AddrW = $clog2(TABLE_ENTRIES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [7:0]                          aging_limit,
   // operation start
   input  logic                                start,
   input  logic [1:0]                          start_op,
   input  logic [mlta_pkg::MAC_W-1:0]          start_mac,
   input  logic [mlta_pkg::PORT_W-1:0]         start_port,
   output logic                                idle,
   // result hand-off
   input  logic                                out_free,
   output logic                                done,
   output mlta_pkg::result_type                result,
   // entry memory
   output logic                                rd_en,
   output logic [AddrW-1:0]                    rd_addr,
   input  mlta_pkg::entry_type                 rd_data,
   output logic                                wr_en,
   output logic [AddrW-1:0]                    wr_addr,
   output mlta_pkg::entry_type                 wr_data
);

   localparam int               CntW     = $clog2(TABLE_ENTRIES + 1);
   localparam logic [AddrW-1:0] LAST_IDX = AddrW'(TABLE_ENTRIES - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic             iss_done_ff, iss_done_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             found_ff, found_in;
   logic             free_ff, free_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   // payload
   logic [1:0]                  op_ff, op_in;
   logic [mlta_pkg::MAC_W-1:0]  mac_ff, mac_in;
   logic [mlta_pkg::PORT_W-1:0] port_ff, port_in;
   logic [AddrW-1:0]            rd_idx_ff, rd_idx_in;
   logic [AddrW-1:0]            found_idx_ff, found_idx_in;
   logic [mlta_pkg::PORT_W-1:0] found_port_ff, found_port_in;
   logic [AddrW-1:0]            free_idx_ff, free_idx_in;

   // per-entry scan terms
   logic                        ent_match;
   logic                        ent_free;
   logic [mlta_pkg::AGE_W-1:0]  age_inc;
   logic                        age_out;

   assign ent_match = rd_data.valid && (rd_data.mac == mac_ff);
   assign ent_free  = !rd_data.valid;
   assign age_inc   = (rd_data.age == mlta_pkg::AGE_MAX) ? rd_data.age
                                                         : rd_data.age + 8'd1;
   assign age_out   = (age_inc >= aging_limit);

   assign idle = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      iss_done_in   = iss_done_ff;
      rd_vld_in     = rd_vld_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      mac_in        = mac_ff;
      port_in       = port_ff;
      rd_idx_in     = rd_idx_ff;
      found_idx_in  = found_idx_ff;
      found_port_in = found_port_ff;
      free_idx_in   = free_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = '0;
      done          = 1'b0;
      result        = '0;

      case (state_ff)
         // sweep every entry to invalid after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AddrW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               op_in       = start_op;
               mac_in      = start_mac;
               port_in     = start_port;
               addr_in     = '0;
               iss_done_in = 1'b0;
               rd_vld_in   = 1'b0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               cnt_in      = '0;
               state_in    = (start_op == mlta_pkg::OP_UNUSED) ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle
            rd_vld_in = 1'b0;
            if (!iss_done_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff;
               if (addr_ff == LAST_IDX) begin
                  iss_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + AddrW'(1);
               end
            end
            // examine the entry read last cycle
            if (rd_vld_ff) begin
               if (ent_match && !found_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = rd_idx_ff;
                  found_port_in = rd_data.port;
               end
               if (ent_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               // aging write-back, behind the read pointer
               if (op_ff == mlta_pkg::OP_TICK && rd_data.valid) begin
                  wr_en       = 1'b1;
                  wr_addr     = rd_idx_ff;
                  wr_data     = rd_data;
                  wr_data.age = age_inc;
                  if (age_out) begin
                     wr_data.valid = 1'b0;
                     cnt_in        = cnt_ff + CntW'(1);
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end

         // final entry write and result hand-off
         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               case (op_ff)
                  mlta_pkg::OP_LOOKUP: begin
                     if (found_ff) begin
                        wr_en             = 1'b1;
                        wr_addr           = found_idx_ff;
                        wr_data.valid     = 1'b1;
                        wr_data.mac       = mac_ff;
                        wr_data.port      = found_port_ff;
                        result.hit        = 1'b1;
                        result.found_port = found_port_ff;
                     end
                  end
                  mlta_pkg::OP_INSERT: begin
                     if (found_ff || free_ff) begin
                        wr_en         = 1'b1;
                        wr_addr       = found_ff ? found_idx_ff : free_idx_ff;
                        wr_data.valid = 1'b1;
                        wr_data.mac   = mac_ff;
                        wr_data.port  = port_ff;
                     end else begin
                        result.table_full = 1'b1;
                     end
                  end
                  mlta_pkg::OP_TICK: begin
                     result.removed_count = mlta_pkg::COUNT_W'(cnt_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         addr_ff     <= '0;
         iss_done_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         iss_done_ff <= iss_done_in;
         rd_vld_ff   <= rd_vld_in;
         found_ff    <= found_in;
         free_ff     <= free_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mac_ff        <= mac_in;
      port_ff       <= port_in;
      rd_idx_ff     <= rd_idx_in;
      found_idx_ff  <= found_idx_in;
      found_port_ff <= found_port_in;
      free_idx_ff   <= free_idx_in;
   end

   // Checks
   `MLTA_ASSERT_IMP(a_no_rw_same_entry, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same entry")
   `MLTA_ASSERT_IMP(a_rd_in_range, rd_en, rd_addr <= LAST_IDX, "read beyond table")
   `MLTA_ASSERT_IMP(a_done_needs_room, done, out_free, "result produced while output is busy")
   `MLTA_ASSERT_IMP(a_full_exclusive, done && result.table_full, !result.hit && result.removed_count == '0, "table_full mixed with other results")
   `MLTA_ASSERT_NXT(a_start_leaves_idle, start && idle, state_ff != ST_IDLE, "accepted beat did not start work")

endmodule

// ===== verif/mac_learning_table_aging_test.sv =====
// ----------------------------------------------------------------------------
// MAC learning table with aging: testbench
// Drives lookup, insert, tick and unused-code beats into the table and checks
// every response beat against a local model of the table held in this module.
// The aging limit register is set over the APB-style port between phases and
// read back. Both streams are throttled at random, in changing mixes.
// ----------------------------------------------------------------------------
module mac_learning_table_aging_test;

   localparam int TABLE_ENTRIES = 64;
   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int TRAFFIC_ITEMS = 400;
   localparam int POOL_SIZE     = 80;

   // CSR byte addresses: aging limit at word 0, word 1 is unmapped
   localparam logic [mlta_pkg::CSR_ADDR_W-1:0] ADDR_AGING_LIMIT =
      {1'b0, mlta_pkg::REG_AGING_LIMIT, 2'b00};
   localparam logic [mlta_pkg::CSR_ADDR_W-1:0] ADDR_SPARE       = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [55:0]                     req_tdata   = '0;  // [47:0] mac_address, [55:48] port
   logic [1:0]                      req_tuser   = mlta_pkg::OP_LOOKUP;  // [1:0] operation
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [23:0]                     rsp_tdata;  // [0] hit, [8:1] found_port, [9] table_full,
                                                // [20:10] removed_count
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [mlta_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   mac_learning_table_aging #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the station table and the aging limit; table starts empty
   logic                          station_valid [TABLE_ENTRIES] = '{default: 1'b0};
   logic [mlta_pkg::MAC_W-1:0]    station_mac   [TABLE_ENTRIES];
   logic [mlta_pkg::PORT_W-1:0]   station_port  [TABLE_ENTRIES];
   logic [mlta_pkg::AGE_W-1:0]    station_age   [TABLE_ENTRIES];
   logic [7:0]                    age_limit = mlta_pkg::AGING_LIMIT_RESET;

   mlta_pkg::result_type          awaited_replies [$];
   logic [mlta_pkg::MAC_W-1:0]    station_pool [POOL_SIZE];

   int failures          = 0;
   int cycle_count       = 0;
   int send_idle_pct     = 21;
   int recv_idle_pct     = 57;
   int traffic_done      = 0;
   int requests_accepted = 0;
   int lookup_hits       = 0;
   int inserts_dropped   = 0;
   int ticks_applied     = 0;
   int stations_aged_out = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Receiver throttle
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic logic [mlta_pkg::MAC_W-1:0] random_station();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Lowest valid slot holding the address, -1 when absent
   function automatic int find_station(input logic [mlta_pkg::MAC_W-1:0] mac);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (station_valid[i] && station_mac[i] == mac) return i;
      return -1;
   endfunction

   // Apply one request to the local table and return the response it earns
   function automatic mlta_pkg::result_type learn_and_age(
      input logic [1:0]                    op,
      input logic [mlta_pkg::MAC_W-1:0]    mac,
      input logic [mlta_pkg::PORT_W-1:0]   port);
      mlta_pkg::result_type r;
      int slot;
      r = '0;
      case (op)
         mlta_pkg::OP_LOOKUP: begin
            slot = find_station(mac);
            if (slot >= 0) begin
               station_age[slot] = '0;
               r.hit = 1'b1;
               r.found_port = station_port[slot];
               lookup_hits++;
            end
         end
         mlta_pkg::OP_INSERT: begin
            slot = find_station(mac);
            if (slot < 0)
               for (int j = 0; j < TABLE_ENTRIES; j++)
                  if (!station_valid[j]) begin
                     slot = j;
                     break;
                  end
            if (slot >= 0) begin
               station_valid[slot] = 1'b1;
               station_mac[slot]   = mac;
               station_port[slot]  = port;
               station_age[slot]   = '0;
            end else begin
               r.table_full = 1'b1;
               inserts_dropped++;
            end
         end
         mlta_pkg::OP_TICK: begin
            ticks_applied++;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!station_valid[i]) continue;
               if (station_age[i] < mlta_pkg::AGE_MAX)
                  station_age[i] = station_age[i] + 1'b1;
               if (station_age[i] >= age_limit) begin
                  station_valid[i] = 1'b0;
                  r.removed_count = r.removed_count + 1'b1;
               end
            end
            stations_aged_out += r.removed_count;
         end
         default: ;  // unused code: no effect
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Response checker: each accepted beat against the oldest prediction
   always @(posedge clock) begin
      mlta_pkg::result_type got;
      mlta_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mlta_pkg::result_type'(rsp_tdata[20:0]);
         if (awaited_replies.size() == 0) begin
            $error("response beat with nothing pending: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("found_port", want.found_port, got.found_port);
            check_field("table_full", want.table_full, got.table_full);
            check_field("removed_count", want.removed_count, got.removed_count);
         end
      end
   end

   // Send one request beat; leaves tvalid high so the caller must send again
   // or drain in the same step
   task automatic send_request(input logic [1:0] op,
                               input logic [mlta_pkg::MAC_W-1:0] mac,
                               input logic [mlta_pkg::PORT_W-1:0] port);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (send_idle_pct != 0 && $urandom_range(49) == 0) gap += $urandom_range(1, 90);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {port, mac};
      do @(posedge clock); while (!req_tready);
      requests_accepted++;
      awaited_replies.push_back(learn_and_age(op, mac, port));
   endtask

   // Stop sending and wait until every predicted response has arrived
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mlta_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_AGING_LIMIT) age_limit = data[7:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [mlta_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      check_field("aging_limit", want, got);
   endtask

   // Change the limit only with the table idle; upper data bits are junk
   task automatic set_aging_limit(input logic [7:0] value);
      wait_drain();
      csr_write(ADDR_AGING_LIMIT, {24'($urandom), value});
      csr_check(ADDR_AGING_LIMIT, {24'b0, value});
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_csr_map();
      csr_check(ADDR_AGING_LIMIT, {24'b0, mlta_pkg::AGING_LIMIT_RESET});
      // unmapped word: write must not disturb the limit
      csr_write(ADDR_SPARE, $urandom);
      csr_check(ADDR_AGING_LIMIT, {24'b0, age_limit});
   endtask

   task automatic test_reset_state();
      send_request(mlta_pkg::OP_LOOKUP, '0, '0);
      send_request(mlta_pkg::OP_LOOKUP, '1, '1);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      send_request(mlta_pkg::OP_UNUSED, '1, '1);
   endtask

   task automatic test_learn_lookup();
      send_request(mlta_pkg::OP_INSERT, '0, 8'hFF);
      send_request(mlta_pkg::OP_INSERT, '1, 8'h00);
      send_request(mlta_pkg::OP_INSERT, 48'h8000_0000_0001, 8'h5A);
      send_request(mlta_pkg::OP_LOOKUP, '0, '1);
      send_request(mlta_pkg::OP_LOOKUP, '1, '0);
      send_request(mlta_pkg::OP_LOOKUP, 48'h0000_0000_0001, 8'h5A);  // near miss
      send_request(mlta_pkg::OP_INSERT, '0, 8'h33);                  // overwrite in place
      send_request(mlta_pkg::OP_LOOKUP, '0, '0);
      send_request(mlta_pkg::OP_UNUSED, '0, 8'hA5);
      send_request(mlta_pkg::OP_LOOKUP, 48'h8000_0000_0001, '0);
   endtask

   task automatic test_aging_edges();
      logic [mlta_pkg::MAC_W-1:0] a, b;
      a = random_station();
      b = a ^ 48'h1;
      // limit 1: one tick clears everything
      set_aging_limit(8'd1);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      send_request(mlta_pkg::OP_LOOKUP, '0, '0);
      // limit 0 behaves like limit 1
      set_aging_limit(8'd0);
      send_request(mlta_pkg::OP_INSERT, a, 8'h01);
      send_request(mlta_pkg::OP_INSERT, b, 8'h80);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      // a lookup hit restarts the age
      set_aging_limit(8'd2);
      send_request(mlta_pkg::OP_INSERT, a, 8'h11);
      send_request(mlta_pkg::OP_INSERT, b, 8'h22);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      send_request(mlta_pkg::OP_LOOKUP, a, '0);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      // limit lowered below an entry's age: it goes on the next tick
      set_aging_limit(8'd5);
      send_request(mlta_pkg::OP_INSERT, b, 8'h44);
      repeat (3) send_request(mlta_pkg::OP_TICK, '0, '0);
      set_aging_limit(8'd2);
      send_request(mlta_pkg::OP_TICK, '0, '0);
   endtask

   task automatic test_table_full();
      logic [mlta_pkg::MAC_W-1:0] filled [TABLE_ENTRIES];
      logic [mlta_pkg::MAC_W-1:0] extra;
      set_aging_limit(8'd1);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      set_aging_limit(mlta_pkg::AGE_MAX);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         filled[i] = {40'(random_station()), 8'(i)};
         send_request(mlta_pkg::OP_INSERT, filled[i], 8'($urandom));
      end
      extra = {40'(random_station()), 8'hFF};
      send_request(mlta_pkg::OP_INSERT, extra, 8'h77);       // dropped
      send_request(mlta_pkg::OP_INSERT, filled[17], 8'hC3);  // present: overwrite
      send_request(mlta_pkg::OP_LOOKUP, extra, '0);
      send_request(mlta_pkg::OP_LOOKUP, filled[17], '0);
      send_request(mlta_pkg::OP_TICK, '0, '0);
      // whole table ages out on one tick
      set_aging_limit(8'd1);
      send_request(mlta_pkg::OP_TICK, '0, '0);
   endtask

   task automatic test_top_limit();
      logic [mlta_pkg::MAC_W-1:0] a, b;
      a = random_station();
      b = ~a;
      set_aging_limit(mlta_pkg::AGE_MAX);
      send_request(mlta_pkg::OP_INSERT, a, 8'h0F);
      send_request(mlta_pkg::OP_INSERT, b, 8'hF0);
      repeat (mlta_pkg::AGE_MAX - 1)
         send_request(mlta_pkg::OP_TICK, random_station(), 8'($urandom));
      send_request(mlta_pkg::OP_LOOKUP, a, '0);
      send_request(mlta_pkg::OP_TICK, '0, '0);  // b reaches 255 and goes
      send_request(mlta_pkg::OP_LOOKUP, b, '0);
      send_request(mlta_pkg::OP_LOOKUP, a, '0);
   endtask

   // One phase of random traffic over a pool of addresses, some one bit off a common base
   task automatic run_traffic(input logic [7:0] limit, input int tick_pct,
                              input int insert_pct, input int count);
      logic [1:0]                 op;
      logic [mlta_pkg::MAC_W-1:0] mac;
      logic [mlta_pkg::MAC_W-1:0] base;
      int                         roll;
      int                         done;
      set_aging_limit(limit);
      base = random_station();
      for (int i = 0; i < POOL_SIZE; i++)
         station_pool[i] = (i % 4 == 0) ?
                           base ^ (48'd1 << $urandom_range(mlta_pkg::MAC_W - 1)) :
                           random_station();
      done = 0;
      while (done < count) begin
         if (traffic_done < TRAFFIC_ITEMS / 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 57;
         end else if (traffic_done < 2 * TRAFFIC_ITEMS / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         roll = $urandom_range(99);
         if (roll < 5) op = mlta_pkg::OP_UNUSED;
         else if (roll < 5 + tick_pct) op = mlta_pkg::OP_TICK;
         else if (roll < 5 + tick_pct + insert_pct) op = mlta_pkg::OP_INSERT;
         else op = mlta_pkg::OP_LOOKUP;
         mac = ($urandom_range(99) < 85) ? station_pool[$urandom_range(POOL_SIZE - 1)]
                                         : random_station();
         send_request(op, mac, 8'($urandom));
         if (op != mlta_pkg::OP_UNUSED) begin
            done++;
            traffic_done++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic(8'd3,              20, 35, 100);
      run_traffic(mlta_pkg::AGE_MAX,  2, 55, 100);  // insert heavy, slow aging
      run_traffic(8'd1,              15, 40, 50);
      // stall the sender once until the table has answered everything
      wait_drain();
      run_traffic(8'd30,             30, 35, 75);
      run_traffic(8'd8,              25, 40, 75);
   endtask

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("mac_learning_table_aging: mismatch");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_csr_map();
      test_reset_state();
      test_learn_lookup();
      test_aging_edges();
      test_table_full();
      test_top_limit();
      test_random_traffic();
      wait_drain();
      repeat (TABLE_ENTRIES + 16) @(posedge clock);
      $display("covered %0d requests: %0d lookup hits, %0d inserts dropped on a full table",
               requests_accepted, lookup_hits, inserts_dropped);
      $display("%0d aging ticks removed %0d stations; limits 0, 1, 2, 3, 5, 8, 30, 255 used",
               ticks_applied, stations_aged_out);
      if (failures == 0)
         $display("mac_learning_table_aging: match");
      else
         $display("mac_learning_table_aging: mismatch");
      $finish;
   end

endmodule
